### hw/rtl/pddm_pkg.sv
// pddm_pkg: shared types and constants for the differential drive pid mixer
// no dependencies
`default_nettype none

package pddm_pkg;

    localparam int POS_W     = 16;
    localparam int ERR_W     = POS_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int ISUM_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int SPEED_W   = 8;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // products: gain is zero-extended by one bit to become a signed operand
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + ISUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W    = PROD_I_W + 2;
    localparam int CORR_W   = ACC_W - FRAC_W;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(128);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = '0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = '0;
    localparam logic [SPEED_W-1:0] BASE_SPEED_RST = SPEED_W'(150);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2,
        CFG_BASE_SPEED = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [ISUM_W-1:0] isum;
        logic signed [DIFF_W-1:0] diff;
    } t_terms;

endpackage

`default_nettype wire

### hw/rtl/pid_differential_drive_mixer.sv
// pid_differential_drive_mixer: top level, config registers, input register, pipeline
// depends on pddm_pkg, pddm_err, pddm_mul, pddm_mix
//
// one line-position sample in, one pair of wheel speeds out. error is the negated
// position; it feeds a saturating 32-bit integral and a difference against the previous
// error, and the correction is (kp*e + ki*integral + kd*diff) / 256 truncated toward
// zero, with all gains unsigned q8.8. right = base + correction, left = base -
// correction, each clamped to 0..255. an item can be accepted every cycle unless the
// output stalls; the accepting edge loads the input register, and the item then moves
// through the error terms, products, correction and result registers in that order.
// the whole pipeline advances together and
// freezes only while a finished result sits at the output and downstream stalls, so
// o_stall follows i_stall combinationally in that case. config is written through the
// plain write port (index 0 kp, 1 ki, 2 kd, 3 base speed) and should only be changed
// while the pipeline is empty.
`default_nettype none

module pid_differential_drive_mixer
    import pddm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config write port
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]    i_cfg_data,
    // sample in
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [POS_W-1:0] i_position,
    // wheel speeds out
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [SPEED_W-1:0]           o_right_speed,
    output logic [SPEED_W-1:0]           o_left_speed
);

    // config registers
    t_gains              r_gains;
    logic [SPEED_W-1:0]  r_base;

    // input register
    logic                    r_in_vld;
    logic signed [POS_W-1:0] r_pos;

    // pipeline advance: only hold when the result register is full and stalled
    logic   adv;
    logic   err_vld;
    t_terms err_terms;
    logic   corr_vld;
    logic signed [CORR_W-1:0] corr;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop  <= PROP_GAIN_RST;
            r_gains.integ <= INTEG_GAIN_RST;
            r_gains.deriv <= DERIV_GAIN_RST;
            r_base        <= BASE_SPEED_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:  r_gains.prop  <= i_cfg_data;
                CFG_INTEG_GAIN: r_gains.integ <= i_cfg_data;
                CFG_DERIV_GAIN: r_gains.deriv <= i_cfg_data;
                CFG_BASE_SPEED: r_base        <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pos <= i_position;
        end
    end

    // error terms and loop state
    pddm_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_in_vld),
        .i_pos   (r_pos),
        .o_vld   (err_vld),
        .o_terms (err_terms)
    );

    // products and truncated correction
    pddm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (err_vld),
        .i_terms (err_terms),
        .i_gains (r_gains),
        .o_vld   (corr_vld),
        .o_corr  (corr)
    );

    // wheel mix and result register
    pddm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (corr_vld),
        .i_corr  (corr),
        .i_base  (r_base),
        .o_vld   (o_valid),
        .o_right (o_right_speed),
        .o_left  (o_left_speed)
    );

endmodule

`default_nettype wire

### hw/rtl/pddm_err.sv
// pddm_err: error, saturating integral and difference, holds the loop state
// depends on pddm_pkg
`default_nettype none

module pddm_err
    import pddm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic signed [POS_W-1:0] i_pos,
    output logic                         o_vld,
    output t_terms                       o_terms
);

    logic signed [ISUM_W-1:0] r_isum;
    logic signed [ERR_W-1:0]  r_prev;
    logic                     r_vld;
    t_terms                   r_terms;

    logic signed [ERR_W-1:0]  n_err;
    logic signed [ISUM_W:0]   n_sum_wide;
    logic signed [ISUM_W-1:0] n_isum;
    logic signed [DIFF_W-1:0] n_diff;

    always_comb begin
        n_err      = -ERR_W'(i_pos);
        n_sum_wide = (ISUM_W+1)'(r_isum) + (ISUM_W+1)'(n_err);
        // saturate when the top two bits disagree
        if (n_sum_wide[ISUM_W] != n_sum_wide[ISUM_W-1]) begin
            n_isum = n_sum_wide[ISUM_W] ? {1'b1, {(ISUM_W-1){1'b0}}}
                                        : {1'b0, {(ISUM_W-1){1'b1}}};
        end else begin
            n_isum = n_sum_wide[ISUM_W-1:0];
        end
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
            r_prev <= '0;
            r_vld  <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_isum <= n_isum;
                r_prev <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms.err  <= n_err;
            r_terms.isum <= n_isum;
            r_terms.diff <= n_diff;
        end
    end

    assign o_vld   = r_vld;
    assign o_terms = r_terms;

endmodule

`default_nettype wire

### hw/rtl/pddm_mul.sv
// pddm_mul: gain products, then their sum truncated toward zero
// depends on pddm_pkg
`default_nettype none

module pddm_mul
    import pddm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  t_terms                        i_terms,
    input  t_gains                        i_gains,
    output logic                          o_vld,
    output logic signed [CORR_W-1:0]      o_corr
);

    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;
    logic                       r_prod_vld;
    logic signed [CORR_W-1:0]   r_corr;
    logic                       r_corr_vld;

    logic signed [ACC_W-1:0]    n_acc;
    logic signed [CORR_W-1:0]   n_corr;

    // stage 1: three independent multiplies
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_p <= $signed({1'b0, i_gains.prop})  * i_terms.err;
            r_prod_i <= $signed({1'b0, i_gains.integ}) * i_terms.isum;
            r_prod_d <= $signed({1'b0, i_gains.deriv}) * i_terms.diff;
        end
    end

    // stage 2: sum and divide by 256 with truncation toward zero
    always_comb begin
        n_acc  = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        n_corr = n_acc[ACC_W-1:FRAC_W]
               + CORR_W'(n_acc[ACC_W-1] && (|n_acc[FRAC_W-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_corr <= n_corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_corr_vld <= 1'b0;
        end else if (i_en) begin
            r_prod_vld <= i_vld;
            r_corr_vld <= r_prod_vld;
        end
    end

    assign o_vld  = r_corr_vld;
    assign o_corr = r_corr;

endmodule

`default_nettype wire

### hw/rtl/pddm_mix.sv
// pddm_mix: base speed plus and minus correction, clamped, result register
// depends on pddm_pkg
`default_nettype none

module pddm_mix
    import pddm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic signed [CORR_W-1:0] i_corr,
    input  wire logic [SPEED_W-1:0]       i_base,
    output logic                          o_vld,
    output logic [SPEED_W-1:0]            o_right,
    output logic [SPEED_W-1:0]            o_left
);

    localparam int SUM_W = CORR_W + 1;

    logic signed [SUM_W-1:0] n_right_raw;
    logic signed [SUM_W-1:0] n_left_raw;
    logic [SPEED_W-1:0]      n_right;
    logic [SPEED_W-1:0]      n_left;
    logic [SPEED_W-1:0]      r_right;
    logic [SPEED_W-1:0]      r_left;
    logic                    r_vld;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] v);
        logic [SPEED_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (|v[SUM_W-2:SPEED_W]) begin
            res = '1;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_right_raw = SUM_W'($signed({1'b0, i_base})) + SUM_W'(i_corr);
        n_left_raw  = SUM_W'($signed({1'b0, i_base})) - SUM_W'(i_corr);
        n_right     = clamp_speed(n_right_raw);
        n_left      = clamp_speed(n_left_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_right <= n_right;
            r_left  <= n_left;
        end
    end

    assign o_vld   = r_vld;
    assign o_right = r_right;
    assign o_left  = r_left;

endmodule

`default_nettype wire

### hw/rtl/pddm_checker.sv
// pddm_checker: port-level checks for pid_differential_drive_mixer, with bind
// depends on pddm_pkg
`default_nettype none

module pddm_checker
    import pddm_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [SPEED_W-1:0] o_right_speed,
    input wire logic [SPEED_W-1:0] o_left_speed
);

    // no result straight out of reset
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input side only stalls when a result is stuck at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // input is never stalled while downstream is not stalling
    a_free_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    // stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_right_speed)
                                  && $stable(o_left_speed)))
        else $error("stalled result changed");

endmodule

bind pid_differential_drive_mixer pddm_checker u_pddm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_right_speed (o_right_speed),
    .o_left_speed  (o_left_speed)
);

`default_nettype wire
